// ===== hw/rtl/palette_key_recolor_defines.svh =====
// ----------------------------------------------------------------------------
// palette key recolor assertion macros
// shared concurrent assertion wrappers, clocked on clk_i, held off in reset
// ----------------------------------------------------------------------------
`ifndef PALETTE_KEY_RECOLOR_DEFINES_SVH
`define PALETTE_KEY_RECOLOR_DEFINES_SVH

// same-cycle implication
`define PRK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("palette_key_recolor: same-cycle check failed");

// next-cycle implication
`define PRK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("palette_key_recolor: next-cycle check failed");

`endif

// ===== hw/rtl/prk_pkg.sv =====
// ----------------------------------------------------------------------------
// prk_pkg
// key colors, shade constants and stage payload types for the recolor pipe
// ----------------------------------------------------------------------------
package prk_pkg;

  localparam int unsigned NumKeys   = 19;
  localparam int unsigned KeyIdxW   = $clog2(NumKeys);
  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned PixelW    = 32;
  localparam int unsigned ProdW     = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned RecipW    = 10;

  // shade index that reproduces the reference color itself
  localparam logic [KeyIdxW-1:0] ShadeRef = KeyIdxW'(14);
  // 205 / 1024 gives exact floor(x / 5) for x below 1024
  localparam logic [ChanW-1:0]   Recip5   = ChanW'(205);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegRefRed   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegRefGreen = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegRefBlue  = CfgIdxW'(2);

  // magenta key colors, darkest to lightest
  localparam logic [23:0] KeyTable [NumKeys] = '{
    24'h3F0016, 24'h55002A, 24'h690039, 24'h7B0045, 24'h8C0051,
    24'h9E005D, 24'hB10069, 24'hC30074, 24'hD6007F, 24'hEC008C,
    24'hEE3D96, 24'hEF5BA1, 24'hF172AC, 24'hF287B6, 24'hF49AC1,
    24'hF6ADCD, 24'hF8C1D9, 24'hFAD5E5, 24'hFDE9F1
  };

  typedef logic [NumChan-1:0][ChanW-1:0] ref_color_t;

  // after key match
  typedef struct packed {
    logic               hit;
    logic [KeyIdxW-1:0] key_idx;
    logic [PixelW-1:0]  pixel;
  } prk_match_t;

  // after shade multiply
  typedef struct packed {
    logic                              hit;
    logic                              low_shade;
    logic [NumChan-1:0][ProdW-1:0]     prod;
    logic [PixelW-1:0]                 pixel;
  } prk_prod_t;

endpackage

// ===== hw/rtl/palette_key_recolor.sv =====
// ----------------------------------------------------------------------------
// palette_key_recolor
// palette-swap recolor of one ARGB8888 pixel per transaction
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with pixel_in_i. Output channel:
// out_valid_o / out_stall_i with pixel_out_o and key_hit_o. Exactly one
// result transaction leaves for every input transaction, in order.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i (0 red, 1 green,
// 2 blue) and cfg_data_i; ready is always high, index 3 is ignored. Write the
// reference color only while the pipe is empty.
// The result passes three registered stages (key match, shade multiply, scale
// and output register). Throughput: one pixel per clock while out_stall_i is
// low, since every stage takes a new pixel whenever its own one moves on.
// Reset clears all valid bits and the reference color to black.
// When out_stall_i is high the result holds; stages behind it keep filling
// bubbles, and in_stall_o rises only once all three stages hold pixels.
// ----------------------------------------------------------------------------
module palette_key_recolor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [prk_pkg::PixelW-1:0]   pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [prk_pkg::PixelW-1:0]   pixel_out_o,
  output logic                         key_hit_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [prk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [prk_pkg::ChanW-1:0]    cfg_data_i
);
  import prk_pkg::*;

  `include "palette_key_recolor_defines.svh"

  ref_color_t ref_q;
  logic       s1_ready, s1_valid;
  logic       s2_ready, s2_valid;
  logic       s3_ready;
  prk_match_t s1_data;
  prk_prod_t  s2_data;

  // reference color registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegRefRed:   ref_q[0] <= cfg_data_i;
        RegRefGreen: ref_q[1] <= cfg_data_i;
        RegRefBlue:  ref_q[2] <= cfg_data_i;
        default:     ref_q    <= ref_q;
      endcase
    end
  end

  // pipe stages
  prk_key_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (s1_ready),
    .pixel_i     (pixel_in_i),
    .out_valid_o (s1_valid),
    .out_ready_i (s2_ready),
    .out_data_o  (s1_data)
  );

  prk_shade_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ref_color_i (ref_q),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s2_ready),
    .in_data_i   (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s3_ready),
    .out_data_o  (s2_data)
  );

  prk_shade_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ref_color_i (ref_q),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s3_ready),
    .in_data_i   (s2_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_o     (pixel_out_o),
    .key_hit_o   (key_hit_o)
  );

  assign in_stall_o = !s1_ready;

  // a replaced pixel is always a visible one
  `PRK_ASSERT_NOW(a_hit_visible, out_valid_o && key_hit_o, pixel_out_o[31:24] != 8'h00)
  // back-pressure only when the whole pipe is full behind a stalled result
  `PRK_ASSERT_NOW(a_stall_full, in_stall_o, out_valid_o && out_stall_i && s1_valid && s2_valid)
  // a taken result with nothing in the multiply stage leaves the output empty
  `PRK_ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !s2_valid, !out_valid_o)

endmodule

// ===== hw/rtl/prk_key_match.sv =====
// ----------------------------------------------------------------------------
// prk_key_match
// first stage: compares the pixel rgb against the key colors
// ----------------------------------------------------------------------------
module prk_key_match (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [prk_pkg::PixelW-1:0] pixel_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output prk_pkg::prk_match_t       out_data_o
);
  import prk_pkg::*;

  logic       valid_q;
  prk_match_t data_d, data_q;
  logic       any_match;
  logic [KeyIdxW-1:0] idx;

  // keys are distinct, so an or of the matching indexes is the index
  always_comb begin
    any_match = 1'b0;
    idx       = '0;
    for (int unsigned k = 0; k < NumKeys; k++) begin
      if (pixel_i[23:0] == KeyTable[k]) begin
        any_match = 1'b1;
        idx       = idx | KeyIdxW'(k);
      end
    end
    data_d.hit     = any_match && (pixel_i[31:24] != 8'h00);
    data_d.key_idx = idx;
    data_d.pixel   = pixel_i;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/prk_shade_mul.sv =====
// ----------------------------------------------------------------------------
// prk_shade_mul
// second stage: per-channel shade product from key index and reference color
// ----------------------------------------------------------------------------
module prk_shade_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prk_pkg::ref_color_t   ref_color_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  prk_pkg::prk_match_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output prk_pkg::prk_prod_t    out_data_o
);
  import prk_pkg::*;

  logic               valid_q;
  prk_prod_t          data_d, data_q;
  logic               low_shade;
  logic [KeyIdxW-1:0] factor;

  // darker shades scale c by (k+2)/16, lighter ones blend (255-c) by (k-14)/5
  assign low_shade = (in_data_i.key_idx <= ShadeRef);
  assign factor    = low_shade ? (in_data_i.key_idx + KeyIdxW'(2))
                               : (in_data_i.key_idx - ShadeRef);

  always_comb begin
    data_d.hit       = in_data_i.hit;
    data_d.low_shade = low_shade;
    data_d.pixel     = in_data_i.pixel;
    for (int unsigned c = 0; c < NumChan; c++) begin
      logic [ChanW-1:0] base;
      base           = low_shade ? ref_color_i[c] : (8'hFF - ref_color_i[c]);
      data_d.prod[c] = ProdW'(base) * ProdW'(factor);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/prk_shade_out.sv =====
// ----------------------------------------------------------------------------
// prk_shade_out
// last stage: scales the products into channels and holds the result
// ----------------------------------------------------------------------------
module prk_shade_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  prk_pkg::ref_color_t        ref_color_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  prk_pkg::prk_prod_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [prk_pkg::PixelW-1:0] pixel_o,
  output logic                       key_hit_o
);
  import prk_pkg::*;

  logic                           valid_q;
  logic [PixelW-1:0]              pixel_d, pixel_q;
  logic                           hit_q;
  logic [NumChan-1:0][ChanW-1:0]  shade;

  // low shades: product / 16; high shades: c + product / 5
  always_comb begin
    for (int unsigned c = 0; c < NumChan; c++) begin
      logic [RecipW+ChanW-1:0] scaled;
      scaled = in_data_i.prod[c][RecipW-1:0] * Recip5;
      if (in_data_i.low_shade) begin
        shade[c] = in_data_i.prod[c][ProdW-1:4];
      end else begin
        shade[c] = ref_color_i[c] + scaled[RecipW+ChanW-1:RecipW];
      end
    end
    pixel_d = in_data_i.hit ? {in_data_i.pixel[31:24], shade[0], shade[1], shade[2]}
                            : in_data_i.pixel;
  end

  assign in_ready_o = !valid_q || !out_stall_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pixel_q <= pixel_d;
      hit_q   <= in_data_i.hit;
    end
  end

  assign out_valid_o = valid_q;
  assign pixel_o     = pixel_q;
  assign key_hit_o   = hit_q;

endmodule
